@@ sv/press_time_region_switch_assert.svh @@
// Assertion macros for the press-time region switch.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PRESS_TIME_REGION_SWITCH_ASSERT_SVH
`define PRESS_TIME_REGION_SWITCH_ASSERT_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("press_time_region_switch: invariant violated");
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("press_time_region_switch: sequence check failed");
`else
`define PTS_ASSERT_ALWAYS(label, clk, rst, expr)
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/pts_pkg.sv @@
// Shared types, constants and helper functions for the press-time region switch.
// No dependencies; used by pts_csr, pts_core and the top level.
`default_nettype none
package pts_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int SLOW_BLINKS = 2;
   localparam int FAST_BLINKS = 5;

   localparam int CMP_W     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int HALVES_W  = 4;
   localparam int HALVES_MAX = (SLOW_BLINKS > FAST_BLINKS) ? 2 * SLOW_BLINKS
                                                           : 2 * FAST_BLINKS;

   // region codes
   localparam logic [1:0] REG_EUR = 2'd0;
   localparam logic [1:0] REG_USA = 2'd1;
   localparam logic [1:0] REG_JAP = 2'd2;
   localparam logic [1:0] REG_CUS = 2'd3;

   // beep codes
   localparam logic [1:0] BEEP_OFF  = 2'd0;
   localparam logic [1:0] BEEP_LOW  = 2'd1;
   localparam logic [1:0] BEEP_HIGH = 2'd2;

   // register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_FREQ_THR   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REGION_THR = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BEEP       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOW_HALF  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAST_HALF  = 3'd5;

   // reset values
   localparam logic [15:0] DEF_FREQ_THR   = 16'd1000;
   localparam logic [15:0] DEF_REGION_THR = 16'd2000;
   localparam logic [7:0]  DEF_PULSE      = 8'd150;
   localparam logic [7:0]  DEF_BEEP       = 8'd200;
   localparam logic [7:0]  DEF_SLOW_HALF  = 8'd125;
   localparam logic [7:0]  DEF_FAST_HALF  = 8'd50;

   typedef struct packed {
      logic [15:0] freq_thr;
      logic [15:0] region_thr;
      logic [7:0]  pulse_ticks;
      logic [7:0]  beep_ticks;
      logic [7:0]  slow_half;
      logic [7:0]  fast_half;
   } cfg_type;

   typedef struct packed {
      logic [1:0] region_now;
      logic [1:0] beep_kind;
      logic       led_blue;
      logic       led_green;
      logic       led_red;
      logic       reset_drive;
      logic       ntsc_60hz;
      logic       not_japanese;
   } res_type;

   function automatic logic is_fast(input logic [1:0] r);
      return (r == REG_USA) || (r == REG_JAP);
   endfunction

   // 50/60 Hz toggle
   function automatic logic [1:0] toggled(input logic [1:0] r);
      logic [1:0] t;
      unique case (r)
         REG_EUR: t = REG_USA;
         REG_USA: t = REG_EUR;
         REG_JAP: t = REG_CUS;
         default: t = REG_JAP;
      endcase
      return t;
   endfunction

   // region cycle, custom falls back to Europe
   function automatic logic [1:0] cycled(input logic [1:0] r);
      logic [1:0] t;
      unique case (r)
         REG_EUR: t = REG_USA;
         REG_USA: t = REG_JAP;
         default: t = REG_EUR;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

@@ sv/pts_csr.sv @@
// Configuration register bank of the press-time region switch.
// Depends on pts_pkg.
`default_nettype none
module pts_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [pts_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [pts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output pts_pkg::cfg_type                      cfg
);

   pts_pkg::cfg_type cfg_ff;
   pts_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pts_pkg::CSR_FREQ_THR:   cfg_in.freq_thr    = csr_wdata;
            pts_pkg::CSR_REGION_THR: cfg_in.region_thr  = csr_wdata;
            pts_pkg::CSR_PULSE:      cfg_in.pulse_ticks = csr_wdata[7:0];
            pts_pkg::CSR_BEEP:       cfg_in.beep_ticks  = csr_wdata[7:0];
            pts_pkg::CSR_SLOW_HALF:  cfg_in.slow_half   = csr_wdata[7:0];
            pts_pkg::CSR_FAST_HALF:  cfg_in.fast_half   = csr_wdata[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq_thr    <= pts_pkg::DEF_FREQ_THR;
         cfg_ff.region_thr  <= pts_pkg::DEF_REGION_THR;
         cfg_ff.pulse_ticks <= pts_pkg::DEF_PULSE;
         cfg_ff.beep_ticks  <= pts_pkg::DEF_BEEP;
         cfg_ff.slow_half   <= pts_pkg::DEF_SLOW_HALF;
         cfg_ff.fast_half   <= pts_pkg::DEF_FAST_HALF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ sv/pts_core.sv @@
// Press timing, region selection, blink, pulse and beep timers.
// Depends on pts_pkg and press_time_region_switch_assert.svh.
`default_nettype none
`include "press_time_region_switch_assert.svh"
module pts_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       pressed,
   input  wire pts_pkg::cfg_type cfg,
   output pts_pkg::res_type res
);

   localparam logic [pts_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [pts_pkg::COUNT_BITS-1:0] press_ticks_ff, press_ticks_in, press_m;
   logic                           armed_ff, armed_in, armed_m;
   logic [1:0]                     region_ff, region_in, region_m;
   logic [7:0]                     blink_timer_ff, blink_timer_in, blink_m;
   logic [pts_pkg::HALVES_W-1:0]   halves_ff, halves_in, halves_m;
   logic [7:0]                     pulse_ff, pulse_in, pulse_m;
   logic [7:0]                     beep_ff, beep_in, beep_m;
   logic [1:0]                     tone_ff, tone_in, tone_m;
   logic                           busy;
   logic                           check;
   logic                           enter;
   logic [1:0]                     target;
   logic                           led_on;
   logic [pts_pkg::CMP_W-1:0]      press_cmp_old, press_cmp_new, freq_cmp, region_cmp;

   assign busy       = (halves_ff != '0) || (pulse_ff != '0);
   assign freq_cmp   = pts_pkg::CMP_W'(cfg.freq_thr);
   assign region_cmp = pts_pkg::CMP_W'(cfg.region_thr);
   assign press_cmp_old = pts_pkg::CMP_W'(press_ticks_ff);

   // sample handling
   always_comb begin
      press_m = press_ticks_ff;
      armed_m = armed_ff;
      pulse_m = pulse_ff;
      check   = 1'b0;
      enter   = 1'b0;
      target  = region_ff;
      if (busy) begin
         armed_m = 1'b0;
      end else if (pressed) begin
         if (press_ticks_ff != '0) begin
            if (press_ticks_ff < COUNT_MAX) begin
               press_m = press_ticks_ff + pts_pkg::COUNT_BITS'(1);
               check   = 1'b1;
            end
         end else if (armed_ff) begin
            armed_m = 1'b0;
            press_m = pts_pkg::COUNT_BITS'(1);
            check   = 1'b1;
         end
      end else if (press_ticks_ff != '0) begin
         if (press_cmp_old >= region_cmp) begin
            enter  = 1'b1;
            target = pts_pkg::cycled(region_ff);
         end else if (press_cmp_old >= freq_cmp) begin
            enter  = 1'b1;
            target = pts_pkg::toggled(region_ff);
         end else begin
            pulse_m = cfg.pulse_ticks;
         end
         press_m = '0;
         armed_m = 1'b0;
      end else begin
         armed_m = 1'b1;
      end
   end

   assign press_cmp_new = pts_pkg::CMP_W'(press_m);

   // beep start on the tick a threshold is reached; low threshold wins a tie
   always_comb begin
      beep_m = beep_ff;
      tone_m = tone_ff;
      if (check) begin
         priority if (press_cmp_new == freq_cmp) begin
            beep_m = cfg.beep_ticks;
            tone_m = pts_pkg::BEEP_LOW;
         end else if (press_cmp_new == region_cmp) begin
            beep_m = cfg.beep_ticks;
            tone_m = pts_pkg::BEEP_HIGH;
         end else begin
            beep_m = beep_ff;
            tone_m = tone_ff;
         end
      end
   end

   // region entry restarts the blink
   always_comb begin
      region_m = region_ff;
      blink_m  = blink_timer_ff;
      halves_m = halves_ff;
      if (enter) begin
         region_m = target;
         blink_m  = pts_pkg::is_fast(target) ? cfg.fast_half : cfg.slow_half;
         halves_m = pts_pkg::is_fast(target) ? pts_pkg::HALVES_W'(2 * pts_pkg::FAST_BLINKS)
                                             : pts_pkg::HALVES_W'(2 * pts_pkg::SLOW_BLINKS);
      end
   end

   // result of this tick
   always_comb begin
      led_on           = !((halves_m != '0) && !halves_m[0]);
      res.not_japanese = !region_m[1];
      res.ntsc_60hz    = pts_pkg::is_fast(region_m);
      res.reset_drive  = (pulse_m != '0);
      res.led_red      = led_on && ((region_m == pts_pkg::REG_JAP) ||
                                    (region_m == pts_pkg::REG_CUS));
      res.led_green    = led_on && (region_m == pts_pkg::REG_USA);
      res.led_blue     = led_on && ((region_m == pts_pkg::REG_EUR) ||
                                    (region_m == pts_pkg::REG_CUS));
      res.beep_kind    = (beep_m != '0) ? tone_m : pts_pkg::BEEP_OFF;
      res.region_now   = region_m;
   end

   // timers count down after the result is formed
   always_comb begin
      press_ticks_in = press_m;
      armed_in       = armed_m;
      region_in      = region_m;
      tone_in        = tone_m;
      beep_in        = (beep_m != '0) ? beep_m - 8'd1 : beep_m;
      pulse_in       = (pulse_m != '0) ? pulse_m - 8'd1 : pulse_m;
      blink_timer_in = blink_m;
      halves_in      = halves_m;
      if (halves_m != '0) begin
         if (blink_m <= 8'd1) begin
            halves_in      = halves_m - pts_pkg::HALVES_W'(1);
            blink_timer_in = pts_pkg::is_fast(region_m) ? cfg.fast_half : cfg.slow_half;
         end else begin
            blink_timer_in = blink_m - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ticks_ff <= '0;
         armed_ff       <= 1'b0;
         region_ff      <= pts_pkg::REG_EUR;
         blink_timer_ff <= pts_pkg::DEF_SLOW_HALF;
         halves_ff      <= pts_pkg::HALVES_W'(2 * pts_pkg::SLOW_BLINKS);
         pulse_ff       <= '0;
         beep_ff        <= pts_pkg::DEF_BEEP;
         tone_ff        <= pts_pkg::BEEP_HIGH;
      end else if (step) begin
         press_ticks_ff <= press_ticks_in;
         armed_ff       <= armed_in;
         region_ff      <= region_in;
         blink_timer_ff <= blink_timer_in;
         halves_ff      <= halves_in;
         pulse_ff       <= pulse_in;
         beep_ff        <= beep_in;
         tone_ff        <= tone_in;
      end
   end

   // a pulse and a blink are never started while the other runs
   `PTS_ASSERT_ALWAYS(a_pulse_blink_excl, clock, reset, (pulse_ff == '0) || (halves_ff == '0))
   // a press in progress has already consumed the armed flag
   `PTS_ASSERT_ALWAYS(a_armed_idle, clock, reset, !armed_ff || (press_ticks_ff == '0))
   `PTS_ASSERT_ALWAYS(a_halves_max, clock, reset, halves_ff <= pts_pkg::HALVES_MAX)
   // samples taken while busy leave the press counter alone
   `PTS_ASSERT_NEXT(a_busy_hold, clock, reset, step && busy, $stable(press_ticks_ff))

endmodule
`default_nettype wire

@@ sv/press_time_region_switch.sv @@
// Press-time region switch: one button sample per transaction, one result per sample.
// Latency: the result of a sample appears on rsp_ the cycle after it is accepted.
// Throughput: one transaction per cycle; req_tready drops only while a result waits
// in the output register and rsp_tready is low.
// Reset (synchronous, active high): registers to defaults, Europe selected,
// startup blink and high beep armed, button ignored until first release.
// Depends on pts_pkg, pts_csr and pts_core.
`default_nettype none
module press_time_region_switch (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input stream
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [7:0]                       req_tdata,   // [0] button_pressed
   // result stream
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] not_japanese, [1] ntsc_60hz, [2] reset_drive, [3] led_red,
   // [4] led_green, [5] led_blue, [7:6] beep_kind, [9:8] region_now
   output      logic [15:0]                      rsp_tdata,
   // configuration writes
   input  wire logic                             csr_we,
   input  wire logic [pts_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [pts_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   pts_pkg::cfg_type cfg;
   pts_pkg::res_type res;
   logic             req_fire;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff, rsp_data_in;

   // accept whenever the output register is empty or being drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   pts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state advances only on an accepted transaction
   pts_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (req_fire),
      .pressed (req_tdata[0]),
      .cfg     (cfg),
      .res     (res)
   );

   // pack the result fields, lowest field first
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (req_fire) begin
         rsp_data_in = {6'd0, res.region_now, res.beep_kind, res.led_blue,
                        res.led_green, res.led_red, res.reset_drive,
                        res.ntsc_60hz, res.not_japanese};
      end
   end

   // hold valid until the consumer takes the result
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

@@ bench/tb_press_time_region_switch.sv @@
// Self-checking bench for press_time_region_switch: directed steps, then random presses.
// Depends on pts_pkg and the RTL top; predicts each result itself unless a drill step types it.
`timescale 1ns / 100ps
module tb_press_time_region_switch;

   localparam int HOLD_MAX    = (1 << pts_pkg::COUNT_BITS) - 1;  // press counter saturates
   localparam int PIPE_CYCLES = 4;          // idle cycles after the last result
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int PHASE_ITEMS = 20;         // live samples per random phase

   // Result right after reset: Europe, startup blink in its off half, high beep.
   localparam pts_pkg::res_type AFTER_RESET = '{pts_pkg::REG_EUR, pts_pkg::BEEP_HIGH,
                                                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   typedef enum logic [1:0] {STEP_TICK, STEP_HOLD, STEP_SETUP} step_kind_type;

   typedef struct packed {
      step_kind_type    kind;
      logic             pressed;  // sample value for a single tick
      int               count;    // press length, or setting number for a setup step
      logic             typed;    // result given below instead of predicted
      pts_pkg::res_type want;
   } drill_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = '0;   // [0] button_pressed
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // [0] not_japanese, [1] ntsc_60hz, [2] reset_drive, [3] led_red,
   // [4] led_green, [5] led_blue, [7:6] beep_kind, [9:8] region_now
   logic [15:0]                    rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [pts_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [pts_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   press_time_region_switch dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_addr, .csr_wdata
   );

   always #4 clock = ~clock;

   // Register settings: freq, region, pulse, beep, slow half, fast half.
   pts_pkg::cfg_type setting_list [8] = '{
      '{16'd2,     16'd3,     8'd2,   8'd2,   8'd1,   8'd1},    // short drill presses
      '{16'd3,     16'd6,     8'd1,   8'd3,   8'd2,   8'd1},
      '{16'd5,     16'd2,     8'd3,   8'd1,   8'd1,   8'd2},    // thresholds out of order
      '{16'd1,     16'd1,     8'd2,   8'd4,   8'd1,   8'd1},    // equal, smallest
      '{16'd4,     16'd40,    8'd2,   8'd2,   8'd1,   8'd3},
      '{16'd3,     16'd5,     8'd0,   8'd0,   8'd0,   8'd0},    // zero lengths
      '{16'd65535, 16'd65535, 8'd255, 8'd255, 8'd255, 8'd255},  // largest
      '{16'd7,     16'd12,    8'd5,   8'd9,   8'd3,   8'd2}
   };
   int random_settings [6] = '{1, 2, 3, 4, 5, 7};

   drill_step_type drill_plan [16] = '{
      '{STEP_TICK,  1'b0, 0, 1'b1, AFTER_RESET},
      '{STEP_TICK,  1'b1, 0, 1'b1, AFTER_RESET},   // press during startup blink: ignored
      '{STEP_TICK,  1'b0, 0, 1'b1, AFTER_RESET},
      '{STEP_SETUP, 1'b0, 0, 1'b0, '0},
      '{STEP_HOLD,  1'b1, 1, 1'b0, '0},            // short: console reset pulse
      '{STEP_TICK,  1'b1, 0, 1'b0, '0},            // press during the pulse: ignored
      '{STEP_HOLD,  1'b1, 2, 1'b0, '0},            // medium: EUR to USA, low beep
      '{STEP_HOLD,  1'b1, 2, 1'b0, '0},            // USA to EUR
      '{STEP_HOLD,  1'b1, 3, 1'b0, '0},            // long: EUR to USA, both beeps
      '{STEP_HOLD,  1'b1, 3, 1'b0, '0},            // USA to JAP
      '{STEP_HOLD,  1'b1, 2, 1'b0, '0},            // JAP to CUS
      '{STEP_TICK,  1'b1, 0, 1'b0, '0},            // press during the blink: ignored
      '{STEP_HOLD,  1'b1, 2, 1'b0, '0},            // CUS to JAP
      '{STEP_HOLD,  1'b1, 3, 1'b0, '0},            // JAP to EUR
      '{STEP_HOLD,  1'b1, 3, 1'b0, '0},            // EUR to USA
      '{STEP_HOLD,  1'b1, 4, 1'b0, '0}             // long past threshold: USA to JAP
   };

   // Predicted switch state and its copy of the registers.
   pts_pkg::cfg_type cfg_shadow;
   int         hold_count;      // press length so far, 0 = no press running
   logic       armed;           // a released sample has been seen while idle
   logic [1:0] region;
   logic [7:0] blink_left;      // ticks left in the current blink half
   logic [3:0] halves_left;
   logic [7:0] pulse_left;
   logic [7:0] beep_left;
   logic [1:0] beep_tone;

   pts_pkg::res_type pending_results [$];
   pts_pkg::res_type got_res, want_res;
   int      error_count = 0;
   int      live_items  = 0;    // samples that met an idle switch
   int      burst_left  = 0;
   int      cycle_count = 0;

   logic [7:0] ready_mask = 8'hFF;
   logic [5:0] ready_pos  = '0;

   function automatic logic [7:0] half_for(input logic [1:0] r);
      return (r == pts_pkg::REG_USA || r == pts_pkg::REG_JAP) ? cfg_shadow.fast_half
                                                              : cfg_shadow.slow_half;
   endfunction

   // Enter a region and start its blink, off half first.
   function automatic void switch_to(input logic [1:0] r);
      region      = r;
      blink_left  = half_for(r);
      halves_left = (r == pts_pkg::REG_USA || r == pts_pkg::REG_JAP)
                    ? 4'(2 * pts_pkg::FAST_BLINKS) : 4'(2 * pts_pkg::SLOW_BLINKS);
   endfunction

   // A beep starts only on the tick the count lands on a threshold; low wins a tie.
   function automatic void sound_at_threshold();
      if (hold_count == cfg_shadow.freq_thr) begin
         beep_tone = pts_pkg::BEEP_LOW;
         beep_left = cfg_shadow.beep_ticks;
      end else if (hold_count == cfg_shadow.region_thr) begin
         beep_tone = pts_pkg::BEEP_HIGH;
         beep_left = cfg_shadow.beep_ticks;
      end
   endfunction

   // Advance the predicted switch by one sample and return the result it shows.
   function automatic pts_pkg::res_type advance_switch(input logic pressed);
      pts_pkg::res_type r;
      logic    led_on;
      if (halves_left != 0 || pulse_left != 0) begin
         // blink or pulse running: drop the sample, need a fresh release later
         armed = 1'b0;
      end else if (pressed) begin
         if (hold_count != 0) begin
            if (hold_count < HOLD_MAX) begin
               hold_count++;
               sound_at_threshold();
            end
         end else if (armed) begin
            armed      = 1'b0;
            hold_count = 1;
            sound_at_threshold();
         end
      end else if (hold_count != 0) begin
         // press ended: region cycle is tested first, then the frequency toggle
         if (hold_count >= cfg_shadow.region_thr) begin
            unique case (region)
               pts_pkg::REG_EUR: switch_to(pts_pkg::REG_USA);
               pts_pkg::REG_USA: switch_to(pts_pkg::REG_JAP);
               default:          switch_to(pts_pkg::REG_EUR);
            endcase
         end else if (hold_count >= cfg_shadow.freq_thr) begin
            unique case (region)
               pts_pkg::REG_EUR: switch_to(pts_pkg::REG_USA);
               pts_pkg::REG_USA: switch_to(pts_pkg::REG_EUR);
               pts_pkg::REG_JAP: switch_to(pts_pkg::REG_CUS);
               default:          switch_to(pts_pkg::REG_JAP);
            endcase
         end else begin
            pulse_left = cfg_shadow.pulse_ticks;
         end
         hold_count = 0;
         armed      = 1'b0;
      end else begin
         armed = 1'b1;
      end

      led_on         = !(halves_left != 0 && !halves_left[0]);
      r.not_japanese = (region == pts_pkg::REG_EUR || region == pts_pkg::REG_USA);
      r.ntsc_60hz    = (region == pts_pkg::REG_USA || region == pts_pkg::REG_JAP);
      r.reset_drive  = (pulse_left != 0);
      r.led_red      = led_on && (region == pts_pkg::REG_JAP || region == pts_pkg::REG_CUS);
      r.led_green    = led_on && (region == pts_pkg::REG_USA);
      r.led_blue     = led_on && (region == pts_pkg::REG_EUR || region == pts_pkg::REG_CUS);
      r.beep_kind    = (beep_left != 0) ? beep_tone : pts_pkg::BEEP_OFF;
      r.region_now   = region;

      // timers run down after the result is formed
      if (beep_left != 0) begin
         beep_left--;
      end
      if (pulse_left != 0) begin
         pulse_left--;
      end
      if (halves_left != 0) begin
         if (blink_left <= 1) begin
            halves_left--;
            blink_left = half_for(region);
         end else begin
            blink_left--;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got_val,
                                  input logic [15:0] want_val);
      error_count++;
      $display("[%0t] %s: got %0d, want %0d", $time, what, got_val, want_val);
   endtask

   task automatic check_field(input string what, input logic [1:0] got_val,
                              input logic [1:0] want_val);
      if (got_val !== want_val) begin
         report_mismatch(what, {14'd0, got_val}, {14'd0, want_val});
      end
   endtask

   // Offer one sample, hold it until taken, then log what the switch should answer.
   task automatic send_sample(input logic pressed, input logic typed,
                              input pts_pkg::res_type typed_val);
      int               gap;
      pts_pkg::res_type predicted;
      if (burst_left == 0) begin
         // start a new burst, sometimes right away, sometimes after a gap
         burst_left = $urandom_range(1, 48);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, pressed};
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (halves_left == 0 && pulse_left == 0) begin
         live_items++;
      end
      predicted = advance_switch(pressed);
      pending_results.push_back(typed ? typed_val : predicted);
   endtask

   // Ride out any blink or pulse (with random samples), release until armed,
   // then hold the button for len ticks and let go.
   task automatic hold_press(input int len);
      while (halves_left != 0 || pulse_left != 0 || hold_count != 0 || !armed) begin
         if (halves_left != 0 || pulse_left != 0) begin
            send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
         end else begin
            send_sample(1'b0, 1'b0, '0);
         end
      end
      repeat (len) send_sample(1'b1, 1'b0, '0);
      send_sample(1'b0, 1'b0, '0);
   endtask

   // Stop sending until every outstanding result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   // Write all six registers; junk in the upper byte of the 8-bit ones must be dropped.
   task automatic write_setting(input pts_pkg::cfg_type s);
      csr_we    <= 1'b1;
      csr_addr  <= pts_pkg::CSR_FREQ_THR;
      csr_wdata <= s.freq_thr;
      @(posedge clock);
      csr_addr  <= pts_pkg::CSR_REGION_THR;
      csr_wdata <= s.region_thr;
      @(posedge clock);
      csr_addr  <= pts_pkg::CSR_PULSE;
      csr_wdata <= {8'($urandom), s.pulse_ticks};
      @(posedge clock);
      csr_addr  <= pts_pkg::CSR_BEEP;
      csr_wdata <= {8'($urandom), s.beep_ticks};
      @(posedge clock);
      csr_addr  <= pts_pkg::CSR_SLOW_HALF;
      csr_wdata <= {8'($urandom), s.slow_half};
      @(posedge clock);
      csr_addr  <= pts_pkg::CSR_FAST_HALF;
      csr_wdata <= {8'($urandom), s.fast_half};
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_shadow = s;
   endtask

   // Receiver: walk an 8-bit ready pattern, reload it each time the 6-bit position wraps.
   // Bit 0 is always set, so a stall ends at the latest when the walk returns to bit 0.
   always @(posedge clock) begin
      if (ready_pos == 6'd63) begin
         ready_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      ready_pos  <= ready_pos + 6'd1;
      rsp_tready <= ready_mask[ready_pos[2:0]];
   end

   // Check each result transaction against the oldest prediction, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no transaction pending", rsp_tdata, 16'd0);
         end else begin
            want_res = pending_results.pop_front();
            got_res  = pts_pkg::res_type'(rsp_tdata[9:0]);
            check_field("not_japanese", {1'b0, got_res.not_japanese},
                        {1'b0, want_res.not_japanese});
            check_field("ntsc_60hz",    {1'b0, got_res.ntsc_60hz},
                        {1'b0, want_res.ntsc_60hz});
            check_field("reset_drive",  {1'b0, got_res.reset_drive},
                        {1'b0, want_res.reset_drive});
            check_field("led_red",      {1'b0, got_res.led_red},
                        {1'b0, want_res.led_red});
            check_field("led_green",    {1'b0, got_res.led_green},
                        {1'b0, want_res.led_green});
            check_field("led_blue",     {1'b0, got_res.led_blue},
                        {1'b0, want_res.led_blue});
            check_field("beep_kind",    got_res.beep_kind,    want_res.beep_kind);
            check_field("region_now",   got_res.region_now,   want_res.region_now);
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("press_time_region_switch regression: fail");
      $finish;
   end

   initial begin
      int pick;
      int press_len;

      // Predicted state after reset: defaults, Europe, startup blink and high beep.
      cfg_shadow = '{pts_pkg::DEF_FREQ_THR, pts_pkg::DEF_REGION_THR, pts_pkg::DEF_PULSE,
                     pts_pkg::DEF_BEEP, pts_pkg::DEF_SLOW_HALF, pts_pkg::DEF_FAST_HALF};
      hold_count = 0;
      armed      = 1'b0;
      pulse_left = '0;
      beep_tone  = pts_pkg::BEEP_HIGH;
      beep_left  = pts_pkg::DEF_BEEP;
      switch_to(pts_pkg::REG_EUR);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed steps: startup, every region move but custom to Europe, presses while busy.
      foreach (drill_plan[i]) begin
         unique case (drill_plan[i].kind)
            STEP_TICK: begin
               send_sample(drill_plan[i].pressed, drill_plan[i].typed, drill_plan[i].want);
            end
            STEP_HOLD: begin
               hold_press(drill_plan[i].count);
            end
            default: begin
               drain_results();
               write_setting(setting_list[drill_plan[i].count]);
            end
         endcase
      end

      // Random phases: mostly whole presses aimed at the thresholds, some noise.
      foreach (random_settings[i]) begin
         drain_results();
         write_setting(setting_list[random_settings[i]]);
         live_items = 0;
         while (live_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               case ($urandom_range(0, 6))
                  0: press_len = $urandom_range(1, 3);
                  1: press_len = int'(cfg_shadow.freq_thr) - 1;
                  2: press_len = int'(cfg_shadow.freq_thr);
                  3: press_len = int'(cfg_shadow.freq_thr) + 1;
                  4: press_len = int'(cfg_shadow.region_thr) - 1;
                  5: press_len = int'(cfg_shadow.region_thr);
                  default: press_len = int'(cfg_shadow.region_thr) + $urandom_range(1, 3);
               endcase
               if (press_len < 1) begin
                  press_len = 1;
               end
               if (press_len > 60) begin
                  press_len = $urandom_range(1, 60);
               end
               hold_press(press_len);
            end
            // now and then hold off until the switch has answered everything
            if (pick == 50) begin
               drain_results();
            end
         end
      end

      // Largest settings: let any running blink end first, then short presses
      // with the longest pulse.
      while (halves_left != 0 || pulse_left != 0) begin
         send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
      end
      drain_results();
      write_setting(setting_list[6]);
      hold_press(1);
      hold_press(2);

      drain_results();
      if (error_count == 0) begin
         $display("press_time_region_switch regression: pass");
      end else begin
         $display("press_time_region_switch regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/pts_pkg.sv
sv/pts_csr.sv
sv/pts_core.sv
sv/press_time_region_switch.sv
bench/tb_press_time_region_switch.sv
